// ===== rtl/assert_macros.svh =====
// Shared assertion macros for the line rasterizer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside of reset.
`define LR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("line rasterizer assertion failed");

// Check that a registered signal group holds while a condition is true.
`define LR_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
	else $error("line rasterizer signal did not hold");

`endif

// ===== rtl/lr_pkg.sv =====
package lr_pkg;

	// Input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Controller states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic setup;
		logic step;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic final_px;
	} status_t;

endpackage

// ===== rtl/lr_ctrl.sv =====
module lr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            command,
	output logic            out_valid,
	input  logic            out_ready,
	input  lr_pkg::status_t status,
	output lr_pkg::cmd_t    cmd
);
	import lr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	// Accept input while not in setup and the output register is free or draining
	assign in_ready = (state_q != ST_SETUP) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Decode datapath commands
	assign cmd.capture = accept && (command == CMD_LOAD);
	assign cmd.setup   = (state_q == ST_SETUP);
	assign cmd.step    = accept && (command == CMD_STEP) && (state_q == ST_RUN);

	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.capture) state_d = ST_SETUP;
				else if (cmd.step && status.final_px) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/lr_datapath.sv =====
module lr_datapath #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  lr_pkg::cmd_t                  cmd,
	output lr_pkg::status_t               status,
	input  logic signed [COORD_WIDTH-1:0] x_start,
	input  logic signed [COORD_WIDTH-1:0] y_start,
	input  logic signed [COORD_WIDTH-1:0] x_end,
	input  logic signed [COORD_WIDTH-1:0] y_end,
	input  logic        [15:0]            color_in,
	output logic signed [COORD_WIDTH-1:0] pixel_x,
	output logic signed [COORD_WIDTH-1:0] pixel_y,
	output logic        [15:0]            pixel_color,
	output logic                          last
);
	import lr_pkg::*;

	localparam int CW = COORD_WIDTH;

	// Capture stage
	logic signed [CW:0]   dx;
	logic signed [CW:0]   dy;
	logic        [CW:0]   adx;
	logic        [CW:0]   ady;
	logic                 steep;
	logic signed [CW-1:0] a_maj_q;
	logic signed [CW-1:0] a_min_q;
	logic signed [CW-1:0] b_maj_q;
	logic signed [CW-1:0] b_min_q;
	logic                 steep_q;
	logic        [15:0]   color_q;

	// Setup stage
	logic                 swap;
	logic signed [CW-1:0] s_maj;
	logic signed [CW-1:0] s_min;
	logic signed [CW-1:0] e_maj;
	logic signed [CW-1:0] e_min;
	logic signed [CW:0]   dmaj;
	logic signed [CW:0]   dmin_raw;
	logic signed [CW:0]   dmin;

	// Walk state
	logic signed [CW-1:0] major_pos_q;
	logic signed [CW-1:0] minor_pos_q;
	logic signed [CW-1:0] major_end_q;
	logic signed [CW:0]   dmin_q;
	logic signed [CW:0]   diff_q;
	logic signed [CW+1:0] err_q;
	logic                 minor_down_q;
	logic signed [CW+1:0] err_sub;
	logic signed [CW+1:0] err_wrap;
	logic                 final_px;

	// Decide steepness and exchange axes
	assign dx    = (CW+1)'(x_end) - (CW+1)'(x_start);
	assign dy    = (CW+1)'(y_end) - (CW+1)'(y_start);
	assign adx   = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
	assign ady   = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
	assign steep = ady > adx;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			steep_q <= steep;
			a_maj_q <= steep ? y_start : x_start;
			a_min_q <= steep ? x_start : y_start;
			b_maj_q <= steep ? y_end : x_end;
			b_min_q <= steep ? x_end : y_end;
			color_q <= color_in;
		end
	end

	// Order endpoints by major coordinate and derive deltas
	assign swap     = a_maj_q > b_maj_q;
	assign s_maj    = swap ? b_maj_q : a_maj_q;
	assign s_min    = swap ? b_min_q : a_min_q;
	assign e_maj    = swap ? a_maj_q : b_maj_q;
	assign e_min    = swap ? a_min_q : b_min_q;
	assign dmaj     = (CW+1)'(e_maj) - (CW+1)'(s_maj);
	assign dmin_raw = (CW+1)'(e_min) - (CW+1)'(s_min);
	assign dmin     = dmin_raw[CW] ? (CW+1)'(-dmin_raw) : dmin_raw;

	// Error update: subtract minor delta, add major delta back on underflow
	assign err_sub  = err_q - (CW+2)'(dmin_q);
	assign err_wrap = err_q + (CW+2)'(diff_q);
	assign final_px = major_pos_q >= major_end_q;
	assign status.final_px = final_px;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			major_pos_q  <= s_maj;
			minor_pos_q  <= s_min;
			major_end_q  <= e_maj;
			dmin_q       <= dmin;
			diff_q       <= dmaj - dmin;
			err_q        <= (CW+2)'(dmaj >>> 1);
			minor_down_q <= !(s_min < e_min);
		end else if (cmd.step && !final_px) begin
			major_pos_q <= major_pos_q + CW'(1);
			if (err_sub[CW+1]) begin
				minor_pos_q <= minor_down_q ? minor_pos_q - CW'(1) : minor_pos_q + CW'(1);
				err_q       <= err_wrap;
			end else begin
				err_q <= err_sub;
			end
		end
	end

	// Output register for the emitted pixel
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pixel_x     <= steep_q ? minor_pos_q : major_pos_q;
			pixel_y     <= steep_q ? major_pos_q : minor_pos_q;
			pixel_color <= color_q;
			last        <= final_px;
		end
	end

endmodule

// ===== rtl/line_rasterizer.sv =====
// Bresenham line rasterizer. A transaction with command 0 loads a line from two
// signed endpoints and a color and gives no pixel; command 1 gives the next pixel
// of the current line, with last set on its final pixel, and gives nothing when no
// line is in progress. A load during a line replaces it. Step transactions are taken
// one per clock while no pixel is stalled at the output; a load is first captured,
// and endpoint ordering and delta setup then run in a register stage after capture,
// during which in_ready is low. Pixels leave through an output register, so the
// next transaction is taken in the same cycle that a waiting pixel is taken.
module line_rasterizer #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [COORD_WIDTH-1:0] x_start,
	input  logic signed [COORD_WIDTH-1:0] y_start,
	input  logic signed [COORD_WIDTH-1:0] x_end,
	input  logic signed [COORD_WIDTH-1:0] y_end,
	input  logic        [15:0]            color_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] pixel_x,
	output logic signed [COORD_WIDTH-1:0] pixel_y,
	output logic        [15:0]            pixel_color,
	output logic                          last
);
	import lr_pkg::*;

	cmd_t    cmd;
	status_t status;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lr_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.color_in    (color_in),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule

// ===== rtl/lr_checker.sv =====
`include "assert_macros.svh"

module lr_checker #(
	parameter int COORD_WIDTH = 12
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] pixel_x,
	input logic signed [COORD_WIDTH-1:0] pixel_y,
	input logic        [15:0]            pixel_color,
	input logic                          last
);
	import lr_pkg::*;

	logic load_acc;
	logic out_stall;

	assign load_acc  = in_valid && in_ready && (command == CMD_LOAD);
	assign out_stall = out_valid && !out_ready;

	// Hold a stalled pixel
	`LR_ASSERT_HOLD(a_pixel_hold, clk, arst_n, out_stall, {pixel_x, pixel_y, pixel_color, last})

	// Stop taking input while a pixel is stalled
	`LR_ASSERT(a_stall_blocks_input, clk, arst_n, out_stall |-> !in_ready)

	// A load gives no pixel and blocks input during its setup state
	`LR_ASSERT(a_load_setup, clk, arst_n, load_acc |=> (!out_valid && !in_ready))

	// A load is followed by input being ready again after setup
	`LR_ASSERT(a_setup_ends, clk, arst_n, load_acc |=> ##1 in_ready)

endmodule

bind line_rasterizer lr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lr_checker (.*);
